/* rtl/ptlik_pkg.sv */
// Shared types, codes and constants of the two-link inverse kinematics block.
package ptlik_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 18;
    localparam int CNT_W = 6;
    localparam int DIV_STEPS = 17;
    localparam int SQRT_STEPS = 17;

    localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;

    localparam logic [2:0] REG_LINK1 = 3'd0;
    localparam logic [2:0] REG_LINK2 = 3'd1;
    localparam logic [2:0] REG_STROKE = 3'd2;
    localparam logic [2:0] REG_SHO_OFS = 3'd3;
    localparam logic [2:0] REG_ELB_OFS = 3'd4;

    typedef logic [4:0] op_t;

    localparam op_t OP_IDLE = 5'd0;
    localparam op_t OP_XX = 5'd1;
    localparam op_t OP_YY = 5'd2;
    localparam op_t OP_SUMSQ = 5'd3;
    localparam op_t OP_DIFSQ = 5'd4;
    localparam op_t OP_A1SQ = 5'd5;
    localparam op_t OP_A2SQ = 5'd6;
    localparam op_t OP_A12 = 5'd7;
    localparam op_t OP_DEN = 5'd8;
    localparam op_t OP_CSEL = 5'd9;
    localparam op_t OP_DIV = 5'd10;
    localparam op_t OP_DIVEND = 5'd11;
    localparam op_t OP_CC = 5'd12;
    localparam op_t OP_SQINIT = 5'd13;
    localparam op_t OP_SQ = 5'd14;
    localparam op_t OP_SQEND = 5'd15;
    localparam op_t OP_CINIT = 5'd16;
    localparam op_t OP_CNORM = 5'd17;
    localparam op_t OP_CITER = 5'd18;
    localparam op_t OP_CEND = 5'd19;
    localparam op_t OP_A2C = 5'd20;
    localparam op_t OP_A2S = 5'd21;
    localparam op_t OP_K1X = 5'd22;
    localparam op_t OP_K2Y = 5'd23;
    localparam op_t OP_K2X = 5'd24;
    localparam op_t OP_K1Y = 5'd25;
    localparam op_t OP_ACC = 5'd26;
    localparam op_t OP_FINISH = 5'd27;

    typedef struct packed {
        logic signed [23:0] target_x;
        logic signed [23:0] target_y;
        logic signed [23:0] target_z;
    } in_item_t;

    typedef struct packed {
        logic               status;
        logic signed [19:0] joint_shoulder;
        logic signed [19:0] joint_elbow;
        logic signed [23:0] joint_slide;
    } out_item_t;

    typedef struct packed {
        logic             load;
        op_t              op;
        logic [CNT_W-1:0] idx;
        logic             phase;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic c_direct;
        logic norm_done;
        logic out_busy;
    } sts_t;

    function automatic logic [30:0] atan_q30(input logic [4:0] k);
        logic [30:0] v;
        case (k)
            5'd0: v = 31'd843314857;
            5'd1: v = 31'd497837830;
            5'd2: v = 31'd263043837;
            5'd3: v = 31'd133525159;
            5'd4: v = 31'd67021687;
            5'd5: v = 31'd33543515;
            5'd6: v = 31'd16775851;
            5'd7: v = 31'd8388438;
            5'd8: v = 31'd4194283;
            5'd9: v = 31'd2097149;
            5'd31: v = 31'd0;
            default: v = 31'd1 << (5'd30 - k);
        endcase
        return v;
    endfunction

endpackage

/* rtl/ptlik_ctrl.sv */
// Sequencer that steps the inverse kinematics datapath through one request.
module ptlik_ctrl #(
    parameter int CORDIC_ITERATIONS = ptlik_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ptlik_pkg::sts_t sts,
    output ptlik_pkg::cmd_t cmd
);
    import ptlik_pkg::*;

    localparam logic [4:0] S_IDLE = OP_IDLE;
    localparam logic [4:0] S_XX = OP_XX;
    localparam logic [4:0] S_YY = OP_YY;
    localparam logic [4:0] S_SUMSQ = OP_SUMSQ;
    localparam logic [4:0] S_DIFSQ = OP_DIFSQ;
    localparam logic [4:0] S_A1SQ = OP_A1SQ;
    localparam logic [4:0] S_A2SQ = OP_A2SQ;
    localparam logic [4:0] S_A12 = OP_A12;
    localparam logic [4:0] S_DEN = OP_DEN;
    localparam logic [4:0] S_CSEL = OP_CSEL;
    localparam logic [4:0] S_DIV = OP_DIV;
    localparam logic [4:0] S_DIVEND = OP_DIVEND;
    localparam logic [4:0] S_CC = OP_CC;
    localparam logic [4:0] S_SQINIT = OP_SQINIT;
    localparam logic [4:0] S_SQ = OP_SQ;
    localparam logic [4:0] S_SQEND = OP_SQEND;
    localparam logic [4:0] S_CINIT = OP_CINIT;
    localparam logic [4:0] S_CNORM = OP_CNORM;
    localparam logic [4:0] S_CITER = OP_CITER;
    localparam logic [4:0] S_CEND = OP_CEND;
    localparam logic [4:0] S_A2C = OP_A2C;
    localparam logic [4:0] S_A2S = OP_A2S;
    localparam logic [4:0] S_K1X = OP_K1X;
    localparam logic [4:0] S_K2Y = OP_K2Y;
    localparam logic [4:0] S_K2X = OP_K2X;
    localparam logic [4:0] S_K1Y = OP_K1Y;
    localparam logic [4:0] S_ACC = OP_ACC;
    localparam logic [4:0] S_FINISH = OP_FINISH;

    logic [4:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             phase_reg, phase_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_XX;
            S_XX:
            begin
                state_next = S_YY;
                phase_next = 1'b0;
            end
            S_YY:     state_next = S_SUMSQ;
            S_SUMSQ:  state_next = S_DIFSQ;
            S_DIFSQ:  state_next = S_A1SQ;
            S_A1SQ:   state_next = S_A2SQ;
            S_A2SQ:   state_next = S_A12;
            S_A12:    state_next = S_DEN;
            S_DEN:    state_next = sts.bad ? S_FINISH : S_CSEL;
            S_CSEL:   state_next = sts.c_direct ? S_CC : S_DIV;
            S_DIV:    if (cnt_reg == CNT_W'(DIV_STEPS - 1)) state_next = S_DIVEND;
            S_DIVEND: state_next = S_CC;
            S_CC:     state_next = S_SQINIT;
            S_SQINIT: state_next = S_SQ;
            S_SQ:     if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) state_next = S_SQEND;
            S_SQEND:  state_next = S_CINIT;
            S_CINIT:  state_next = S_CNORM;
            S_CNORM:  if (sts.norm_done) state_next = S_CITER;
            S_CITER:
                if (cnt_reg == CNT_W'(CORDIC_ITERATIONS - 1)) state_next = S_CEND;
            S_CEND:   state_next = phase_reg ? S_FINISH : S_A2C;
            S_A2C:    state_next = S_A2S;
            S_A2S:    state_next = S_K1X;
            S_K1X:    state_next = S_K2Y;
            S_K2Y:    state_next = S_K2X;
            S_K2X:    state_next = S_K1Y;
            S_K1Y:    state_next = S_ACC;
            S_ACC:
            begin
                state_next = S_CINIT;
                phase_next = 1'b1;
            end
            S_FINISH: if (!sts.out_busy) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
        // The step counter runs while a state repeats and restarts on any move.
        cnt_next = (state_next == state_reg) ? cnt_reg + 1'b1 : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        cmd.load  = in_valid && in_ready;
        cmd.op    = (state_reg == S_FINISH && sts.out_busy) ? OP_IDLE : state_reg;
        cmd.idx   = cnt_reg;
        cmd.phase = phase_reg;
    end

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_XX))
        else $error("accepted request did not start the sequence");
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg < CNT_W'(DIV_STEPS)))
        else $error("division ran past its step count");
    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CITER) |-> (cnt_reg < CNT_W'(CORDIC_ITERATIONS)))
        else $error("rotation ran past its iteration count");
    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && sts.out_busy) |=> (state_reg == S_FINISH))
        else $error("result dropped while output register was full");
`endif

endmodule

/* rtl/ptlik_dpath.sv */
// Datapath: shared multiplier, divider, square root, vectoring rotator, registers.
module ptlik_dpath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ptlik_pkg::cmd_t      cmd,
    output ptlik_pkg::sts_t      sts,
    input  ptlik_pkg::in_item_t  in_data,
    input  logic                 cfg_valid,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ptlik_pkg::out_item_t out_data
);
    import ptlik_pkg::*;

    function automatic logic signed [19:0] sat20(input logic signed [21:0] v);
        logic signed [19:0] r;
        if (v > 22'sd524287) r = 20'sd524287;
        else if (v < -22'sd524288) r = -20'sd524288;
        else r = v[19:0];
        return r;
    endfunction

    function automatic logic [56:0] mag57(input logic signed [56:0] v);
        return v[56] ? 57'(-v) : 57'(v);
    endfunction

    logic [22:0]        a1_reg, a2_reg, d3_reg;
    logic signed [19:0] sho_reg, elb_reg, prev_reg;

    logic signed [23:0] x_reg, y_reg, z_reg;
    logic signed [51:0] prod_reg, r2_reg, num_reg, den_reg, accx_reg, accy_reg;
    logic               bad_reg;
    logic [64:0]        rem_reg;
    logic [16:0]        q_reg;
    logic signed [17:0] c_reg, s_reg;
    logic [32:0]        sv_reg;
    logic [33:0]        sr_reg, sb_reg;
    logic signed [56:0] cx_reg, cy_reg;
    logic signed [33:0] cz_reg;
    logic               czero_reg;
    logic signed [20:0] t1_reg, t2_reg;
    logic signed [24:0] k1_reg;
    logic signed [23:0] k2_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    logic signed [25:0] mul_a, mul_b;
    logic signed [23:0] a_dif;
    logic [23:0]        a_sum;
    logic signed [25:0] a1_s, a2_s;

    assign a1_s  = $signed({3'b000, a1_reg});
    assign a2_s  = $signed({3'b000, a2_reg});
    assign a_sum = {1'b0, a1_reg} + {1'b0, a2_reg};
    assign a_dif = $signed({1'b0, a1_reg}) - $signed({1'b0, a2_reg});

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_XX:    begin mul_a = 26'(x_reg);  mul_b = 26'(x_reg); end
            OP_YY:    begin mul_a = 26'(y_reg);  mul_b = 26'(y_reg); end
            OP_SUMSQ: begin mul_a = $signed({2'b00, a_sum}); mul_b = $signed({2'b00, a_sum}); end
            OP_DIFSQ: begin mul_a = 26'(a_dif);  mul_b = 26'(a_dif); end
            OP_A1SQ:  begin mul_a = a1_s;        mul_b = a1_s; end
            OP_A2SQ:  begin mul_a = a2_s;        mul_b = a2_s; end
            OP_A12:   begin mul_a = a1_s;        mul_b = a2_s; end
            OP_CC:    begin mul_a = 26'(c_reg);  mul_b = 26'(c_reg); end
            OP_A2C:   begin mul_a = a2_s;        mul_b = 26'(c_reg); end
            OP_A2S:   begin mul_a = a2_s;        mul_b = 26'(s_reg); end
            OP_K1X:   begin mul_a = 26'(k1_reg); mul_b = 26'(x_reg); end
            OP_K2Y:   begin mul_a = 26'(k2_reg); mul_b = 26'(y_reg); end
            OP_K2X:   begin mul_a = 26'(k2_reg); mul_b = 26'(x_reg); end
            OP_K1Y:   begin mul_a = 26'(k1_reg); mul_b = 26'(y_reg); end
            default:  begin mul_a = '0;          mul_b = '0; end
        endcase
    end

    // Comparisons and step values used by the iterative units.
    logic               z_bad;
    logic [47:0]        num_mag;
    logic [64:0]        div_n, div_d;
    logic [4:0]         div_sh;
    logic [33:0]        sq_trial;
    logic signed [56:0] init_x, init_y;
    logic               c_both_lo, c_both_mid;
    logic [4:0]         k;
    logic signed [33:0] z_rnd;
    logic signed [20:0] t_new;
    logic signed [21:0] d_minus, d_plus, dm_mag, dp_mag;
    logic signed [51:0] prod_rnd;
    logic signed [25:0] slide_full;

    always_comb
    begin
        z_bad = (z_reg > 24'sd0) ||
                ($signed({z_reg[23], z_reg}) < -$signed({2'b00, d3_reg}));
        num_mag = num_reg[51] ? 48'(-num_reg) : 48'(num_reg);
        div_n = {1'b0, num_mag, 16'd0} + 65'(den_reg[51:1]);
        div_sh = 5'(DIV_STEPS - 1) - cmd.idx[4:0];
        div_d = 65'(den_reg) << div_sh;
        sq_trial = sr_reg + sb_reg;
        if (cmd.phase)
        begin
            init_x = 57'(accx_reg);
            init_y = 57'(accy_reg);
        end
        else
        begin
            init_x = 57'(c_reg);
            init_y = 57'(s_reg);
        end
        c_both_lo  = (mag57(cx_reg) < (57'd1 << 44)) && (mag57(cy_reg) < (57'd1 << 44));
        c_both_mid = (mag57(cx_reg) < (57'd1 << 52)) && (mag57(cy_reg) < (57'd1 << 52));
        k = cmd.idx[4:0];
        z_rnd = (cz_reg + 34'sd8192) >>> 14;
        t_new = czero_reg ? 21'sd0 : z_rnd[20:0];
        d_minus = 22'(t_new) - 22'(prev_reg);
        d_plus  = 22'(t_new) + 22'(prev_reg);
        dm_mag = d_minus[21] ? -d_minus : d_minus;
        dp_mag = d_plus[21] ? -d_plus : d_plus;
        prod_rnd = (prod_reg + 52'sd32768) >>> 16;
        slide_full = -$signed({3'b000, d3_reg}) - ($signed({{2{z_reg[23]}}, z_reg}) <<< 1);
    end

    assign sts = '{bad: bad_reg,
                   c_direct: (den_reg == 52'sd0) || (num_reg >= den_reg) ||
                             (num_reg <= -den_reg),
                   norm_done: czero_reg || !c_both_mid,
                   out_busy: out_valid_reg && !out_ready};

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.load)
        begin
            x_reg <= in_data.target_x;
            y_reg <= in_data.target_y;
            z_reg <= in_data.target_z;
        end
        unique case (cmd.op)
            OP_YY:    r2_reg <= prod_reg;
            OP_SUMSQ: r2_reg <= r2_reg + prod_reg;
            OP_DIFSQ: bad_reg <= (r2_reg > prod_reg) || z_bad;
            OP_A1SQ:  if (a1_reg >= a2_reg && r2_reg < prod_reg) bad_reg <= 1'b1;
            OP_A2SQ:  num_reg <= r2_reg - prod_reg;
            OP_A12:   num_reg <= num_reg - prod_reg;
            OP_DEN:   den_reg <= prod_reg <<< 1;
            OP_CSEL:
            begin
                if (den_reg == 52'sd0)
                    c_reg <= num_reg[51] ? -18'sd65536 : 18'sd65536;
                else if (num_reg >= den_reg)
                    c_reg <= 18'sd65536;
                else if (num_reg <= -den_reg)
                    c_reg <= -18'sd65536;
                rem_reg <= div_n;
                q_reg   <= '0;
            end
            OP_DIV:
            begin
                if (rem_reg >= div_d)
                begin
                    rem_reg <= rem_reg - div_d;
                    q_reg   <= {q_reg[15:0], 1'b1};
                end
                else
                    q_reg <= {q_reg[15:0], 1'b0};
            end
            OP_DIVEND:
                c_reg <= num_reg[51] ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
            OP_SQINIT:
            begin
                sv_reg <= (33'd1 << 32) - prod_reg[32:0];
                sr_reg <= '0;
                sb_reg <= 34'd1 << 32;
            end
            OP_SQ:
            begin
                if ({1'b0, sv_reg} >= sq_trial)
                begin
                    sv_reg <= 33'({1'b0, sv_reg} - sq_trial);
                    sr_reg <= (sr_reg >> 1) + sb_reg;
                end
                else
                    sr_reg <= sr_reg >> 1;
                sb_reg <= sb_reg >> 2;
            end
            OP_SQEND: s_reg <= $signed(sr_reg[17:0]);
            OP_CINIT:
            begin
                czero_reg <= (init_x == 57'sd0) && (init_y == 57'sd0);
                if (init_x < 57'sd0)
                begin
                    cz_reg <= (init_y >= 57'sd0) ? PI_Q30 : -PI_Q30;
                    cx_reg <= -init_x;
                    cy_reg <= -init_y;
                end
                else
                begin
                    cz_reg <= '0;
                    cx_reg <= init_x;
                    cy_reg <= init_y;
                end
            end
            OP_CNORM:
            begin
                // Coarse steps of eight keep the scaling short for small vectors.
                if (!czero_reg && c_both_lo)
                begin
                    cx_reg <= cx_reg <<< 8;
                    cy_reg <= cy_reg <<< 8;
                end
                else if (!czero_reg && c_both_mid)
                begin
                    cx_reg <= cx_reg <<< 1;
                    cy_reg <= cy_reg <<< 1;
                end
            end
            OP_CITER:
            begin
                if (cy_reg >= 57'sd0)
                begin
                    cx_reg <= cx_reg + (cy_reg >>> k);
                    cy_reg <= cy_reg - (cx_reg >>> k);
                    cz_reg <= cz_reg + $signed({3'b000, atan_q30(k)});
                end
                else
                begin
                    cx_reg <= cx_reg - (cy_reg >>> k);
                    cy_reg <= cy_reg + (cx_reg >>> k);
                    cz_reg <= cz_reg - $signed({3'b000, atan_q30(k)});
                end
            end
            OP_CEND:
            begin
                if (cmd.phase)
                    t1_reg <= t_new;
                else if (!(dm_mag < dp_mag))
                begin
                    // A tie between the two elbow branches takes the negative one.
                    t2_reg <= -t_new;
                    s_reg  <= -s_reg;
                end
                else
                    t2_reg <= t_new;
            end
            OP_A2S:   k1_reg <= a1_s[24:0] + prod_rnd[24:0];
            OP_K1X:   k2_reg <= prod_rnd[23:0];
            OP_K2Y:   accx_reg <= prod_reg;
            OP_K2X:   accx_reg <= accx_reg + prod_reg;
            OP_K1Y:   accy_reg <= -prod_reg;
            OP_ACC:   accy_reg <= accy_reg + prod_reg;
            OP_FINISH:
            begin
                if (bad_reg)
                    out_reg <= '{status: 1'b1, joint_shoulder: '0, joint_elbow: '0,
                                 joint_slide: '0};
                else
                    out_reg <= '{status: 1'b0,
                                 joint_shoulder: sat20(22'(t1_reg) - 22'(sho_reg)),
                                 joint_elbow: sat20(22'(t2_reg) - 22'(elb_reg)),
                                 joint_slide: slide_full[24:1]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_reg        <= 23'd65536;
            a2_reg        <= 23'd65536;
            d3_reg        <= 23'd65536;
            sho_reg       <= '0;
            elb_reg       <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_LINK1:   a1_reg  <= cfg_data[22:0];
                    REG_LINK2:   a2_reg  <= cfg_data[22:0];
                    REG_STROKE:  d3_reg  <= cfg_data[22:0];
                    REG_SHO_OFS: sho_reg <= $signed(cfg_data[19:0]);
                    REG_ELB_OFS: elb_reg <= $signed(cfg_data[19:0]);
                    default: ;
                endcase
            end
            if (cmd.op == OP_FINISH)
            begin
                out_valid_reg <= 1'b1;
                if (!bad_reg)
                    prev_reg <= sat20(22'(t2_reg) - 22'(elb_reg));
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* rtl/planar_two_link_ik_with_prismatic_z.sv */
// Top level of the two-link planar arm inverse kinematics solver with vertical slide.
//
// One request (x, y, z) in Q8.16 yields one result: status, shoulder and elbow
// angles in Q3.16 radians and the slide position. Requests are solved one at a
// time by a sequencer around a single shared 26x26 multiplier, a radix-2 divider,
// a bit-serial square root and one vectoring rotator that is used twice. An
// unreachable target goes from the reachability checks straight to the result
// register. A solved one also passes through the rotator's pre-scaling, whose
// length depends on the vector, once for the elbow and once for the shoulder
// angle. A new request is taken as soon as the previous one has been written to
// the output register; while a result waits unaccepted the sequencer holds in
// its last step. Configuration writes are always accepted and must only be
// issued while no request is in progress.
module planar_two_link_ik_with_prismatic_z #(
    parameter int CORDIC_ITERATIONS = ptlik_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ptlik_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ptlik_pkg::out_item_t out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data
);
    import ptlik_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    ptlik_ctrl #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ptlik_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
